// ===== sv/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// shared types, constants and round functions of the sha-256 message hasher
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD
    } t_state;

    typedef enum logic [1:0] {
        SEL_IN,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    // controller to datapath
    typedef struct packed {
        logic      push;
        t_byte_sel byte_sel;
        logic      count_msg;
        logic      load_v;
        logic      round;
        logic [5:0] round_idx;
        logic      accum;
        logic      finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [5:0] fill;
        logic       out_busy;
    } t_dp_status;

    function automatic logic [31:0] f_iv(input logic [2:0] idx);
        logic [31:0] r;
        case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] f_k(input logic [5:0] idx);
        logic [31:0] r;
        case (idx)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] f_ror(input logic [31:0] x, input logic [4:0] n);
        return (x >> n) | (x << (6'd32 - {1'b0, n}));
    endfunction

    function automatic logic [31:0] f_big_s0(input logic [31:0] x);
        return f_ror(x, 5'd2) ^ f_ror(x, 5'd13) ^ f_ror(x, 5'd22);
    endfunction

    function automatic logic [31:0] f_big_s1(input logic [31:0] x);
        return f_ror(x, 5'd6) ^ f_ror(x, 5'd11) ^ f_ror(x, 5'd25);
    endfunction

    function automatic logic [31:0] f_sig0(input logic [31:0] x);
        return f_ror(x, 5'd7) ^ f_ror(x, 5'd18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] f_sig1(input logic [31:0] x);
        return f_ror(x, 5'd17) ^ f_ror(x, 5'd19) ^ (x >> 10);
    endfunction

endpackage

// ===== sv/sha256_datapath.sv =====
// ----------------------------------------------------------------------------
// sha256_datapath
// byte packing, message schedule window, round unit, chaining state, digest out
// ----------------------------------------------------------------------------
module sha256_datapath
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [7:0]  i_byte,
    input  logic        i_out_ready,
    output t_dp_status  o_status,
    output logic        o_out_valid,
    output logic [31:0] o_out_word,
    output logic [2:0]  o_out_index,
    output logic        o_out_last
);

    logic [5:0]  r_fill;
    logic [60:0] r_msg;
    logic [23:0] r_acc;
    logic [31:0] r_w     [16];
    logic [31:0] r_v     [8];
    logic [31:0] r_chain [8];
    logic [31:0] r_dig   [8];
    logic        r_out_valid;
    logic [2:0]  r_out_cnt;

    logic [63:0] len_bits;
    logic [63:0] len_shift;
    logic [7:0]  sel_byte;
    logic [31:0] sched;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    assign len_bits  = {r_msg, 3'b000};
    assign len_shift = len_bits >> {~r_fill[2:0], 3'b000};

    always_comb begin
        case (i_cmd.byte_sel)
            SEL_IN:   sel_byte = i_byte;
            SEL_PAD:  sel_byte = PAD_BYTE;
            SEL_LEN:  sel_byte = len_shift[7:0];
            default:  sel_byte = 8'h00;
        endcase
    end

    // next schedule word w[t+16] from the window taps
    assign sched = f_sig1(r_w[14]) + r_w[9] + f_sig0(r_w[1]) + r_w[0];

    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + f_big_s1(r_v[4]) + ch + f_k(i_cmd.round_idx) + r_w[0];
    assign t2  = f_big_s0(r_v[0]) + maj;

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_msg  <= '0;
        end else begin
            if (i_cmd.push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.finish) begin
                r_msg <= '0;
            end else if (i_cmd.push && i_cmd.count_msg) begin
                r_msg <= r_msg + 61'd1;
            end
        end
    end

    // byte packing and schedule window
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            if (r_fill[1:0] == 2'd3) begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i + 1];
                end
                r_w[15] <= {r_acc, sel_byte};
            end else begin
                r_acc <= {r_acc[15:0], sel_byte};
            end
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= sched;
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_v) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_chain[i];
            end
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    // chaining state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= f_iv(3'(i));
            end
        end else if (i_cmd.finish) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= f_iv(3'(i));
            end
        end else if (i_cmd.accum) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= r_chain[i] + r_v[i];
            end
        end
    end

    // digest output buffer, drained one word per handshake
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            for (int i = 0; i < 8; i++) begin
                r_dig[i] <= r_chain[i] + r_v[i];
            end
        end else if (r_out_valid && i_out_ready) begin
            for (int i = 0; i < 7; i++) begin
                r_dig[i] <= r_dig[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_cnt   <= '0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
            r_out_cnt   <= '0;
        end else if (r_out_valid && i_out_ready) begin
            r_out_cnt <= r_out_cnt + 3'd1;
            if (r_out_cnt == 3'd7) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.fill     = r_fill;
    assign o_status.out_busy = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_dig[0];
    assign o_out_index       = r_out_cnt;
    assign o_out_last        = (r_out_cnt == 3'd7);

endmodule

// ===== sv/sha256_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha256_ctrl
// sequencer for byte intake, padding, the 64 rounds and the digest hand-off
// ----------------------------------------------------------------------------
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_has,
    input  logic       i_in_end,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [5:0] r_round, n_round;
    logic       r_padding, n_padding;
    logic       r_pad80, n_pad80;
    logic       r_len_ok, n_len_ok;
    logic       r_final, n_final;
    logic       accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_round   <= '0;
            r_padding <= 1'b0;
            r_pad80   <= 1'b0;
            r_len_ok  <= 1'b0;
            r_final   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_round   <= n_round;
            r_padding <= n_padding;
            r_pad80   <= n_pad80;
            r_len_ok  <= n_len_ok;
            r_final   <= n_final;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_round   = r_round;
        n_padding = r_padding;
        n_pad80   = r_pad80;
        n_len_ok  = r_len_ok;
        n_final   = r_final;
        o_cmd     = '0;
        o_cmd.byte_sel  = SEL_IN;
        o_cmd.round_idx = r_round;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_end) begin
                        n_padding = 1'b1;
                        n_pad80   = 1'b0;
                        n_state   = ST_PAD;
                    end
                    if (i_in_has) begin
                        o_cmd.push      = 1'b1;
                        o_cmd.count_msg = 1'b1;
                        if (i_status.fill == 6'd63) begin
                            o_cmd.load_v = 1'b1;
                            n_round      = '0;
                            n_state      = ST_ROUND;
                        end
                    end
                end
            end
            ST_PAD: begin
                o_cmd.push = 1'b1;
                if (!r_pad80) begin
                    o_cmd.byte_sel = SEL_PAD;
                    n_pad80        = 1'b1;
                    n_len_ok       = (i_status.fill < 6'd56);
                end else if ((i_status.fill[5:3] == 3'd7) && r_len_ok) begin
                    o_cmd.byte_sel = SEL_LEN;
                    if (i_status.fill == 6'd63) begin
                        n_final = 1'b1;
                    end
                end else begin
                    o_cmd.byte_sel = SEL_ZERO;
                end
                if (i_status.fill == 6'd63) begin
                    o_cmd.load_v = 1'b1;
                    n_round      = '0;
                    n_state      = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_round     = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (r_final) begin
                    // hold the finished state until the previous digest has drained
                    if (!i_status.out_busy) begin
                        o_cmd.finish = 1'b1;
                        n_final      = 1'b0;
                        n_padding    = 1'b0;
                        n_pad80      = 1'b0;
                        n_len_ok     = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    o_cmd.accum = 1'b1;
                    if (r_padding) begin
                        n_len_ok = 1'b1;
                        n_state  = ST_PAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_round_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_v |=> (r_state == ST_ROUND) && (r_round == 6'd0))
        else $error("compression did not start after a full block");

    a_finish_only_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !i_status.out_busy)
        else $error("digest overwritten before it was delivered");

    a_no_push_during_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.push && (o_cmd.round || o_cmd.accum || o_cmd.finish)))
        else $error("byte pushed while the window is busy");

    a_final_block_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_final) |-> (r_state == ST_ROUND) && (i_status.fill == 6'd0))
        else $error("length bytes did not close a block");

endmodule

// ===== sv/sha256_message_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_message_hasher
// sha-256 of a byte stream, eight digest words out per message
// ----------------------------------------------------------------------------
// usage:
//   slave channel takes one word per handshake: a message byte in tdata,
//   tuser high when the byte belongs to the message, tlast on the final word
//   of the message (tuser low with tlast hashes an empty tail)
//   master channel returns the eight digest words, index 0 first, tlast on
//   the eighth
// timing:
//   bytes are taken one per cycle; the 64th byte of a block starts the
//   compression rounds and one chaining add, during which tready is low
//   after the final word the sequencer feeds the padding one byte a cycle
//   (up to 72 bytes, two compressions when the tail holds 56 or more bytes)
// stall:
//   the digest sits in its own buffer, so the next message is taken while the
//   receiver stalls; only a second finished digest waits for the first
//   to drain
// reset:
//   synchronous active-low reset restores the initial hash values, clears
//   the byte and length counters and drops m_axis_tvalid
// ----------------------------------------------------------------------------
module sha256_message_hasher
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_axis_tlast    // last_word
);

    // command and status between sequencer and datapath
    t_dp_cmd    cmd;
    t_dp_status status;

    logic [31:0] out_word;
    logic [2:0]  out_index;

    sha256_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_has   (s_axis_tuser),
        .i_in_end   (s_axis_tlast),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    sha256_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_byte      (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_out_word  (out_word),
        .o_out_index (out_index),
        .o_out_last  (m_axis_tlast)
    );

    // digest word in the low bits, its index above, zero fill to a whole byte
    assign m_axis_tdata = {5'b00000, out_index, out_word};

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the sha-256 message hasher
// ----------------------------------------------------------------------------
// drives byte streams into the slave channel and checks every digest word on
// the master channel against an in-bench sha-256 model; a short directed
// table (empty message, "abc", idle words, extreme bytes, empty tails) runs
// first, then random messages through four idling phases with one long
// receiver hold that backs the block up into its input
// ----------------------------------------------------------------------------
module testbench;

    // run shape
    localparam int RAND_WORDS_PER_PHASE = 75;
    localparam int LONG_HOLD_CYCLES     = 1500;
    localparam int DRAIN_CYCLES         = 400;
    localparam int WATCHDOG_LIMIT       = 20000;

    localparam logic [7:0] MSG_PAD_BYTE = 8'h80;

    // well-known digests, read straight off the standard
    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    localparam logic [0:7][31:0] START_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // one expected digest word
    typedef struct {
        logic [31:0] digest;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    // one row of the directed table; known rows carry their digest
    typedef struct {
        logic [7:0]   data;
        logic         has_byte;
        logic         eom;
        logic         known;
        logic [255:0] digest;
    } stim_row_t;

    // dut ports
    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser  = 1'b0;    // [0] has_byte
    logic        s_axis_tlast  = 1'b0;    // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;            // [31:0] digest_word, [34:32] word_index
    logic        m_axis_tlast;            // last_word

    // sha-256 model state
    logic [31:0] chain_h [8];
    logic [7:0]  blk_bytes [64];
    int unsigned blk_fill;
    logic [60:0] msg_byte_count;           // wraps like the 61-bit length counter

    digest_word_t pending_digest_q [$];
    stim_row_t    dir_rows [$];

    // knobs shared between the sender, the receiver and the main sequence
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req_cnt   = 0;
    int unsigned hold_seen_cnt  = 0;
    int unsigned hold_left      = 0;

    // bookkeeping
    int unsigned mismatch_count = 0;
    int unsigned words_in       = 0;
    int unsigned msgs_in        = 0;
    int unsigned bytes_in       = 0;
    int unsigned words_checked  = 0;
    int unsigned phase_words    = 0;
    int unsigned quiet_cycles   = 0;

    sha256_message_hasher uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // sha-256 model
    // ------------------------------------------------------------------------

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void hash_reset();
        for (int i = 0; i < 8; i++) chain_h[i] = START_H[i];
        for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
        blk_fill       = 0;
        msg_byte_count = '0;
    endfunction

    // one 64-round compression of blk_bytes folded into chain_h
    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] va, vb, vc, vd, ve, vf, vg, vh, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        va = chain_h[0]; vb = chain_h[1]; vc = chain_h[2]; vd = chain_h[3];
        ve = chain_h[4]; vf = chain_h[5]; vg = chain_h[6]; vh = chain_h[7];
        for (int t = 0; t < 64; t++) begin
            t1 = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25))
               + ((ve & vf) ^ (~ve & vg)) + ROUND_K[t] + w[t];
            t2 = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22))
               + ((va & vb) ^ (va & vc) ^ (vb & vc));
            vh = vg; vg = vf; vf = ve;
            ve = vd + t1;
            vd = vc; vc = vb; vb = va;
            va = t1 + t2;
        end
        chain_h[0] += va; chain_h[1] += vb; chain_h[2] += vc; chain_h[3] += vd;
        chain_h[4] += ve; chain_h[5] += vf; chain_h[6] += vg; chain_h[7] += vh;
    endfunction

    // takes one accepted word; returns 1 with the finished digest on end of message
    function automatic bit absorb_word(input logic [7:0] data, input logic has_byte,
                                       input logic eom, output logic [255:0] digest);
        logic [63:0] bit_len;
        digest = '0;
        if (has_byte) begin
            blk_bytes[blk_fill] = data;
            blk_fill++;
            msg_byte_count++;
            // a byte that fills the block compresses it at once
            if (blk_fill == 64) begin
                compress_block();
                blk_fill = 0;
            end
        end
        if (!eom)
            return 1'b0;
        blk_bytes[blk_fill] = MSG_PAD_BYTE;
        for (int i = blk_fill + 1; i < 64; i++) blk_bytes[i] = 8'h00;
        // no room for the length: an extra all-padding block
        if (blk_fill >= 56) begin
            compress_block();
            for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
        end
        bit_len = {msg_byte_count, 3'b000};
        for (int i = 0; i < 8; i++) blk_bytes[56+i] = bit_len[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++) digest[255-32*i -: 32] = chain_h[i];
        hash_reset();
        return 1'b1;
    endfunction

    function automatic void queue_digest(input logic [255:0] digest);
        digest_word_t dw;
        for (int i = 0; i < 8; i++) begin
            dw.digest = digest[255-32*i -: 32];
            dw.index  = i[2:0];
            dw.last   = (i == 7);
            pending_digest_q.push_back(dw);
        end
    endfunction

    // ------------------------------------------------------------------------
    // slave side: one word per call, tvalid stays up between back-to-back words
    // ------------------------------------------------------------------------

    task automatic send_word(input logic [7:0] data, input logic has_byte, input logic eom);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tuser  <= 1'($urandom);
            s_axis_tlast  <= 1'($urandom);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= has_byte;
        s_axis_tlast  <= eom;
        do @(posedge i_clk); while (!s_axis_tready);
        if (has_byte || eom)
            words_in++;
        if (has_byte)
            bytes_in++;
        if (eom)
            msgs_in++;
    endtask

    // random-content message; a stray idle word now and then, and sometimes
    // the end comes as a separate empty marker
    task automatic send_message(input int unsigned len, input bit empty_tail);
        logic [7:0]   data;
        logic [255:0] digest;
        bit           eom;
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(99) < 5) begin
                data = 8'($urandom);
                send_word(data, 1'b0, 1'b0);
                void'(absorb_word(data, 1'b0, 1'b0, digest));
            end
            data = 8'($urandom);
            eom  = (i == len - 1) && !empty_tail;
            send_word(data, 1'b1, eom);
            if (absorb_word(data, 1'b1, eom, digest))
                queue_digest(digest);
            phase_words++;
        end
        if (len == 0 || empty_tail) begin
            data = 8'($urandom);
            send_word(data, 1'b0, 1'b1);
            void'(absorb_word(data, 1'b0, 1'b1, digest));
            queue_digest(digest);
            phase_words++;
        end
    endtask

    // mostly short messages, a fair share at the block and padding boundaries,
    // a few long ones
    function automatic int unsigned pick_length();
        int unsigned edge_lens [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        int unsigned r;
        r = $urandom_range(99);
        if (r < 25)
            return edge_lens[$urandom_range(11)];
        else if (r < 90)
            return $urandom_range(40, 1);
        return $urandom_range(130, 41);
    endfunction

    // sender stops until every expected digest word is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_digest_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // master side: check on handshake, then pick the next tready
    // ------------------------------------------------------------------------

    task automatic check_digest_word();
        digest_word_t want;
        if (pending_digest_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: digest word with nothing pending, got word %h index %0d last %b",
                     $time, m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
            return;
        end
        want = pending_digest_q.pop_front();
        words_checked++;
        if (m_axis_tdata[31:0] !== want.digest || m_axis_tdata[34:32] !== want.index
                || m_axis_tlast !== want.last) begin
            mismatch_count++;
            $display("%0t: digest word mismatch, expected %h index %0d last %b, got %h index %0d last %b",
                     $time, want.digest, want.index, want.last,
                     m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_digest_word();
        // a long hold was asked for: counted out here, random stalls after it
        if (hold_req_cnt != hold_seen_cnt) begin
            hold_seen_cnt = hold_req_cnt;
            hold_left     = LONG_HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d digest words still pending",
                     $time, quiet_cycles, pending_digest_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin
        logic [255:0] digest;
        stim_row_t    row;
        bit           done;

        // directed table: after reset, idle words, extreme bytes, byte with
        // end, empty end markers after bytes and on their own
        dir_rows.push_back('{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST});  // empty message
        dir_rows.push_back('{8'hff, 1'b0, 1'b0, 1'b0, '0});            // idle word
        dir_rows.push_back('{8'h61, 1'b1, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h62, 1'b1, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h00, 1'b0, 1'b0, 1'b0, '0});            // idle mid-message
        dir_rows.push_back('{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST});    // "abc"
        dir_rows.push_back('{8'hff, 1'b1, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h00, 1'b1, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h80, 1'b1, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h7f, 1'b1, 1'b1, 1'b0, '0});
        dir_rows.push_back('{8'h55, 1'b1, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'haa, 1'b1, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'hff, 1'b0, 1'b1, 1'b0, '0});            // empty tail after bytes
        dir_rows.push_back('{8'hff, 1'b1, 1'b1, 1'b0, '0});            // single 0xff
        dir_rows.push_back('{8'h00, 1'b1, 1'b1, 1'b0, '0});            // single 0x00
        dir_rows.push_back('{8'h5a, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST});  // empty again

        hash_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            send_word(row.data, row.has_byte, row.eom);
            done = absorb_word(row.data, row.has_byte, row.eom, digest);
            if (done)
                queue_digest(row.known ? row.digest : digest);
        end
        wait_drained();

        // random phases: no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            if (phase == 2) begin
                // receiver holds off while short messages keep coming, so the
                // digest buffer fills and the input backs up
                hold_req_cnt++;
                for (int m = 0; m < 4; m++)
                    send_message($urandom_range(8, 1), 1'b0);
                wait_drained();
            end
            phase_words = 0;
            while (phase_words < RAND_WORDS_PER_PHASE)
                send_message(pick_length(), $urandom_range(9) == 0);
            wait_drained();
        end

        // trailing window to catch any extra digest words
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d messages (%0d bytes, %0d words incl. empty end markers)",
                 msgs_in, bytes_in, words_in);
        $display("checked %0d digest words across four idling phases and a long output hold",
                 words_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sha256_pkg.sv
sv/sha256_datapath.sv
sv/sha256_ctrl.sv
sv/sha256_message_hasher.sv
dv/testbench.sv
